/* rtl/cclp_pkg.sv */
// cclp_pkg: shared constants, codes, result struct and the decimal step
// used by the console command line parser. No dependencies.

package cclp_pkg;

   localparam int unsigned LINE_CAPACITY_DEFAULT = 64;

   // console character codes
   localparam logic [7:0] CH_BS    = 8'd8;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_DEL   = 8'd127;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UP_C  = 8'h43;
   localparam logic [7:0] CH_UP_S  = 8'h53;
   localparam logic [7:0] CH_LO_C  = 8'h63;
   localparam logic [7:0] CH_LO_Q  = 8'h71;
   localparam logic [7:0] CH_LO_R  = 8'h72;
   localparam logic [7:0] CH_LO_S  = 8'h73;
   localparam logic [7:0] CH_LO_T  = 8'h74;
   localparam logic [7:0] CH_LO_V  = 8'h76;
   localparam logic [7:0] CH_LO_W  = 8'h77;

   // result status codes
   localparam logic [1:0] ST_WAIT    = 2'd0;
   localparam logic [1:0] ST_VALID   = 2'd1;
   localparam logic [1:0] ST_INVALID = 2'd2;

   // command kinds
   localparam logic [1:0] CMD_QUIT    = 2'd0;
   localparam logic [1:0] CMD_MOVE    = 2'd1;
   localparam logic [1:0] CMD_REVERSE = 2'd2;
   localparam logic [1:0] CMD_SWITCH  = 2'd3;

   localparam logic [15:0] NUM_MAX = 16'hFFFF;

   // first declared member sits in the highest bits
   typedef struct packed {
      logic        line_discarded;
      logic [15:0] argument;
      logic [15:0] target_number;
      logic [1:0]  command_kind;
      logic [1:0]  status;
   } result_type;

   localparam int unsigned RESULT_W = $bits(result_type);
   localparam int unsigned RSP_DATA_W = ((RESULT_W + 7) / 8) * 8;

   // v * 10 + digit, saturating at NUM_MAX
   function automatic logic [15:0] dec_step(input logic [15:0] v, input logic [7:0] ch);
      logic [19:0] t;
      t = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {16'b0, ch[3:0]};
      if (t > {4'b0, NUM_MAX}) begin
         dec_step = NUM_MAX;
      end else begin
         dec_step = t[15:0];
      end
   endfunction

endpackage

/* rtl/cclp_line_mem.sv */
// cclp_line_mem: line store, one write port and one read port with a
// registered read. Depends on nothing but its parameters.

module cclp_line_mem #(
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [7:0]               wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [7:0]               rd_data
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/cclp_parser.sv */
// cclp_parser: walks the stored line one character a cycle through the
// line store read port and decodes the command. Uses cclp_pkg.

module cclp_parser #(
   parameter int unsigned LINE_CAPACITY = cclp_pkg::LINE_CAPACITY_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [$clog2(LINE_CAPACITY)-1:0] fill,
   input  logic                             take,
   output logic                             done,
   output cclp_pkg::result_type             result,
   output logic [$clog2(LINE_CAPACITY)-1:0] rd_addr,
   input  logic [7:0]                       rd_data
);

   localparam int unsigned ADDR_W = $clog2(LINE_CAPACITY);

   localparam logic [2:0] PH_C0  = 3'd0;
   localparam logic [2:0] PH_C1  = 3'd1;
   localparam logic [2:0] PH_SP1 = 3'd2;
   localparam logic [2:0] PH_N1  = 3'd3;
   localparam logic [2:0] PH_SP2 = 3'd4;
   localparam logic [2:0] PH_N2  = 3'd5;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 pend_ff, pend_in;
   logic                 inrange_ff, inrange_in;
   logic [2:0]           phase_ff, phase_in;
   logic [ADDR_W-1:0]    pos_ff, pos_in;
   logic [ADDR_W-1:0]    fill_ff, fill_in;
   logic [7:0]           c0_ff, c0_in;
   logic [1:0]           cmd_ff, cmd_in;
   logic [15:0]          num1_ff, num1_in;
   logic [15:0]          num2_ff, num2_in;
   cclp_pkg::result_type result_ff, result_in;

   logic [7:0]  ch;
   logic        is_sp, is_dig, dir_s, dir_c;
   logic        fin;
   logic [1:0]  fin_kind;
   logic [15:0] fin_tgt, fin_arg;
   logic        fin_ok;

   assign ch     = inrange_ff ? rd_data : 8'd0;
   assign is_sp  = (ch == cclp_pkg::CH_SPACE);
   assign is_dig = (ch >= cclp_pkg::CH_ZERO) && (ch <= cclp_pkg::CH_NINE);
   assign dir_s  = (ch == cclp_pkg::CH_UP_S) || (ch == cclp_pkg::CH_LO_S);
   assign dir_c  = (ch == cclp_pkg::CH_UP_C) || (ch == cclp_pkg::CH_LO_C);

   always_comb begin
      busy_in    = busy_ff;
      done_in    = done_ff;
      pend_in    = 1'b0;
      inrange_in = 1'b0;
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      fill_in    = fill_ff;
      c0_in      = c0_ff;
      cmd_in     = cmd_ff;
      num1_in    = num1_ff;
      num2_in    = num2_ff;
      result_in  = result_ff;
      fin        = 1'b0;
      fin_ok     = 1'b0;
      fin_kind   = cclp_pkg::CMD_QUIT;
      fin_tgt    = 16'd0;
      fin_arg    = 16'd0;

      if (pend_ff) begin
         case (phase_ff)
            PH_C0: begin
               if (ch == cclp_pkg::CH_LO_Q) begin
                  fin    = 1'b1;
                  fin_ok = 1'b1;
               end else begin
                  c0_in    = ch;
                  phase_in = PH_C1;
               end
            end
            PH_C1: begin
               phase_in = PH_SP1;
               if (c0_ff == cclp_pkg::CH_LO_T && ch == cclp_pkg::CH_LO_R) begin
                  cmd_in = cclp_pkg::CMD_MOVE;
               end else if (c0_ff == cclp_pkg::CH_LO_R && ch == cclp_pkg::CH_LO_V) begin
                  cmd_in = cclp_pkg::CMD_REVERSE;
               end else if (c0_ff == cclp_pkg::CH_LO_S && ch == cclp_pkg::CH_LO_W) begin
                  cmd_in = cclp_pkg::CMD_SWITCH;
               end else begin
                  fin = 1'b1;
               end
            end
            PH_SP1, PH_N1: begin
               if (is_dig) begin
                  num1_in  = cclp_pkg::dec_step(num1_ff, ch);
                  phase_in = PH_N1;
               end else if (is_sp && phase_ff == PH_SP1) begin
                  phase_in = PH_SP1;
               end else begin
                  // end of the target number, this char already belongs to what follows
                  case (cmd_ff)
                     cclp_pkg::CMD_REVERSE: begin
                        fin      = 1'b1;
                        fin_ok   = (num1_ff != 16'd0);
                        fin_kind = cclp_pkg::CMD_REVERSE;
                        fin_tgt  = num1_ff;
                     end
                     cclp_pkg::CMD_MOVE: begin
                        if (is_sp) begin
                           phase_in = PH_SP2;
                        end else begin
                           fin      = 1'b1;
                           fin_ok   = (num1_ff != 16'd0);
                           fin_kind = cclp_pkg::CMD_MOVE;
                           fin_tgt  = num1_ff;
                        end
                     end
                     default: begin
                        if (is_sp) begin
                           phase_in = PH_SP2;
                        end else begin
                           fin      = 1'b1;
                           fin_ok   = (num1_ff != 16'd0) && (dir_s || dir_c);
                           fin_kind = cclp_pkg::CMD_SWITCH;
                           fin_tgt  = num1_ff;
                           fin_arg  = {15'd0, dir_c};
                        end
                     end
                  endcase
               end
            end
            PH_SP2: begin
               if (is_sp) begin
                  phase_in = PH_SP2;
               end else if (cmd_ff == cclp_pkg::CMD_MOVE) begin
                  if (is_dig) begin
                     num2_in  = cclp_pkg::dec_step(num2_ff, ch);
                     phase_in = PH_N2;
                  end else begin
                     fin      = 1'b1;
                     fin_ok   = (num1_ff != 16'd0);
                     fin_kind = cclp_pkg::CMD_MOVE;
                     fin_tgt  = num1_ff;
                     fin_arg  = num2_ff;
                  end
               end else begin
                  fin      = 1'b1;
                  fin_ok   = (num1_ff != 16'd0) && (dir_s || dir_c);
                  fin_kind = cclp_pkg::CMD_SWITCH;
                  fin_tgt  = num1_ff;
                  fin_arg  = {15'd0, dir_c};
               end
            end
            PH_N2: begin
               if (is_dig) begin
                  num2_in = cclp_pkg::dec_step(num2_ff, ch);
               end else begin
                  fin      = 1'b1;
                  fin_ok   = (num1_ff != 16'd0);
                  fin_kind = cclp_pkg::CMD_MOVE;
                  fin_tgt  = num1_ff;
                  fin_arg  = num2_ff;
               end
            end
            default: begin
               fin = 1'b1;
            end
         endcase
      end

      // keep reading ahead one char while the walk goes on
      if (busy_ff && !fin) begin
         pend_in    = 1'b1;
         inrange_in = (pos_ff < fill_ff);
         if (pos_ff < fill_ff) begin
            pos_in = pos_ff + ADDR_W'(1);
         end
      end

      if (fin) begin
         busy_in = 1'b0;
         done_in = 1'b1;
         result_in.line_discarded = 1'b0;
         if (fin_ok) begin
            result_in.status        = cclp_pkg::ST_VALID;
            result_in.command_kind  = fin_kind;
            result_in.target_number = fin_tgt;
            result_in.argument      = fin_arg;
         end else begin
            result_in.status        = cclp_pkg::ST_INVALID;
            result_in.command_kind  = cclp_pkg::CMD_QUIT;
            result_in.target_number = 16'd0;
            result_in.argument      = 16'd0;
         end
      end

      if (take) begin
         done_in = 1'b0;
      end

      if (start) begin
         busy_in  = 1'b1;
         done_in  = 1'b0;
         pend_in  = 1'b0;
         phase_in = PH_C0;
         pos_in   = '0;
         fill_in  = fill;
         num1_in  = 16'd0;
         num2_in  = 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         pend_ff  <= 1'b0;
         phase_ff <= PH_C0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         pend_ff  <= pend_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      inrange_ff <= inrange_in;
      pos_ff     <= pos_in;
      fill_ff    <= fill_in;
      c0_ff      <= c0_in;
      cmd_ff     <= cmd_in;
      num1_ff    <= num1_in;
      num2_ff    <= num2_in;
      result_ff  <= result_in;
   end

   assign done    = done_ff;
   assign result  = result_ff;
   assign rd_addr = pos_ff;

endmodule

/* rtl/console_command_line_parser.sv */
// console_command_line_parser: top level, line editing, fill count and the
// result register. Uses cclp_pkg, cclp_line_mem and cclp_parser.
//
//   channel | dir | payload (tdata, lowest bits first)
//   req_    | in  | byte_in[7:0]
//   rsp_    | out | status[1:0], command_kind[3:2], target_number[19:4],
//           |     | argument[35:20], line_discarded[36], zero[39:37]
//
// an edit byte or appended byte gives its registered result in the cycle after it is taken
// a line end on a non-empty line walks the line store through its single
// read port, one char a cycle, for lines of at most 63 chars
// reset empties the line; the store itself needs no clearing
// req_tready drops while a line is walked or a result waits on a stalled rsp_

module console_command_line_parser #(
   parameter int unsigned LINE_CAPACITY = cclp_pkg::LINE_CAPACITY_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // byte_in
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status, command_kind, target_number, argument, line_discarded, zero pad
   output logic [cclp_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int unsigned ADDR_W = $clog2(LINE_CAPACITY);

   logic                 busy_ff, busy_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   cclp_pkg::result_type rsp_data_ff, rsp_data_in;
   logic [ADDR_W-1:0]    fill_ff, fill_in;

   logic                 out_free, req_acc;
   logic                 is_eol, is_bs;
   logic                 wr_en, start, take, done;
   cclp_pkg::result_type parse_result;
   logic [ADDR_W-1:0]    rd_addr;
   logic [7:0]           rd_data;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !busy_ff && out_free;
   assign req_acc    = req_tvalid && req_tready;
   assign is_eol     = (req_tdata == cclp_pkg::CH_CR) || (req_tdata == cclp_pkg::CH_LF);
   assign is_bs      = (req_tdata == cclp_pkg::CH_BS) || (req_tdata == cclp_pkg::CH_DEL);
   assign take       = busy_ff && done && out_free;

   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      fill_in      = fill_ff;
      wr_en        = 1'b0;
      start        = 1'b0;

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (take) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_data_in  = parse_result;
      end

      if (req_acc) begin
         rsp_data_in.status        = cclp_pkg::ST_WAIT;
         rsp_data_in.command_kind  = cclp_pkg::CMD_QUIT;
         rsp_data_in.target_number = 16'd0;
         rsp_data_in.argument      = 16'd0;
         rsp_data_in.line_discarded = 1'b0;
         rsp_valid_in = 1'b1;
         if (is_eol) begin
            fill_in = '0;
            if (fill_ff != '0) begin
               start        = 1'b1;
               busy_in      = 1'b1;
               rsp_valid_in = 1'b0;
            end
         end else if (is_bs) begin
            if (fill_ff != '0) begin
               fill_in = fill_ff - ADDR_W'(1);
            end
         end else if (fill_ff < ADDR_W'(LINE_CAPACITY - 1)) begin
            wr_en   = 1'b1;
            fill_in = fill_ff + ADDR_W'(1);
         end else begin
            // full store: the byte and the whole line go
            fill_in = '0;
            rsp_data_in.line_discarded = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fill_ff      <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_ff      <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   cclp_line_mem #(
      .DEPTH   (LINE_CAPACITY)
   ) u_line_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff),
      .wr_data (req_tdata),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cclp_parser #(
      .LINE_CAPACITY (LINE_CAPACITY)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .fill    (fill_ff),
      .take    (take),
      .done    (done),
      .result  (parse_result),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(cclp_pkg::RSP_DATA_W - cclp_pkg::RESULT_W)'(0), rsp_data_ff};

endmodule
